// ===== rtl/lmsgb_pkg.sv =====
`default_nettype none
package lmsgb_pkg;

    // Panel geometry
    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 16;
    localparam int BUF_DEPTH   = MAX_COLUMNS * MAX_ROWS;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int COL_IW      = $clog2(MAX_COLUMNS);
    localparam int ROW_IW      = $clog2(MAX_ROWS);
    localparam int COLS_W      = 6;
    localparam int ROWS_W      = 5;
    localparam int REG_AW      = 4;

    typedef logic [BUF_AW-1:0] buf_addr_t;
    typedef logic [7:0]        pixel_t;

    // Register indexes on the APB port
    typedef enum logic [1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1,
        REG_ENABLE  = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    // Pixel byte layout
    localparam logic [1:0] CLASS_OFF    = 2'd0;
    localparam logic [1:0] CLASS_DARK   = 2'd1;
    localparam logic [1:0] CLASS_SHADOW = 2'd2;
    localparam logic [1:0] CLASS_BRIGHT = 2'd3;
    localparam int BIT_BLINK_FAST = 2;
    localparam int BIT_BLINK_MID  = 3;
    localparam int BIT_BLINK_SLOW = 4;
    localparam int BIT_INVERT     = 5;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_FRAME = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } scan_state_t;

    // Decide one pixel: class base state, blink gate, then invert
    function automatic logic pixel_on(
        input pixel_t px,
        input logic   mod3_zero,
        input logic   mod7_zero,
        input logic   bl_fast,
        input logic   bl_mid,
        input logic   bl_slow
    );
        logic on;
        begin
            case (px[1:0])
                CLASS_BRIGHT: on = 1'b1;
                CLASS_SHADOW: on = mod3_zero;
                CLASS_DARK:   on = mod7_zero;
                default:      on = 1'b0;
            endcase
            if (on)
            begin
                if (px[BIT_BLINK_FAST])
                    on = bl_fast;
                else if (px[BIT_BLINK_MID])
                    on = bl_mid;
                else if (px[BIT_BLINK_SLOW])
                    on = bl_slow;
                if (px[BIT_INVERT])
                    on = ~on;
            end
            return on;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/led_matrix_scan_with_grey_and_blink.sv =====
// LED matrix refresh engine with a 512-byte pixel frame buffer.
// Input channel (in_valid/in_ready) carries one item per beat. action 0
// writes pixel_value at pixel_x + pixel_y*columns.
// action 1 refreshes one frame: when display_enable is set the 8-bit
// frame counter advances and one output beat per row is produced
// (row_bits, row_address, last_row), rows in order from 0. With the
// display disabled a frame item is dropped.
// A frame reads one pixel per cycle, while a row is scanned, from the
// single buffer read port; in_ready stays low until the last row is
// loaded into the output register.
// Each row lands in an output register; if out_ready is low the scan
// holds until that register is taken, so stalls only stretch the frame.
// Reset (rst_n, asynchronous, active low) clears the frame counter and
// loads columns 32, rows 16, display on. The buffer is not cleared and
// must be written before it is shown.
// Registers on APB: 0x0 columns_in_use, 0x4 rows_in_use,
// 0x8 display_enable; out-of-range counts are saturated when used.
`default_nettype none
module led_matrix_scan_with_grey_and_blink (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [4:0]  pixel_x,
    input  wire logic [3:0]  pixel_y,
    input  wire logic [7:0]  pixel_value,
    input  wire logic        blink_fast,
    input  wire logic        blink_mid,
    input  wire logic        blink_slow,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      row_bits,
    output logic [3:0]       row_address,
    output logic             last_row
);
    import lmsgb_pkg::*;

    // Configuration registers
    logic [COLS_W-1:0] columns_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic              enable_reg;
    reg_idx_t          reg_idx;
    logic              cfg_wr;

    // Sequencer state
    scan_state_t       state_reg, state_next;
    logic [7:0]        frame_cnt_reg, frame_cnt_next;
    logic [1:0]        mod3_reg, mod3_next;
    logic [2:0]        mod7_reg, mod7_next;
    buf_addr_t         addr_reg, addr_next;
    logic [COL_IW-1:0] col_reg, col_next;
    logic [ROW_IW-1:0] row_reg, row_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [COL_IW-1:0] rd_col_reg;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [MAX_COLUMNS-1:0] acc_reg, acc_next;
    logic [2:0]             blink_reg;
    logic [31:0]            row_bits_reg;
    logic [3:0]             row_address_reg;
    logic                   last_row_reg;

    // Effective geometry
    logic [COLS_W-1:0] cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic              col_last;
    logic              row_last;

    // Write address and buffer ports
    logic [9:0]        wr_sum;
    logic              in_fire;
    logic              buf_wr_en;
    pixel_t            rd_data;
    logic              pix_on;
    logic              load_out;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Register file write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLS_W'(MAX_COLUMNS);
            rows_reg    <= ROWS_W'(MAX_ROWS);
            enable_reg  <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_COLUMNS: columns_reg <= pwdata[COLS_W-1:0];
                REG_ROWS:    rows_reg    <= pwdata[ROWS_W-1:0];
                REG_ENABLE:  enable_reg  <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // Register file read
    always_comb
    begin
        case (reg_idx)
            REG_COLUMNS: prdata = {{(32-COLS_W){1'b0}}, columns_reg};
            REG_ROWS:    prdata = {{(32-ROWS_W){1'b0}}, rows_reg};
            REG_ENABLE:  prdata = {31'd0, enable_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Saturate counts into the panel range
    always_comb
    begin
        if (columns_reg == '0)
            cols_eff = COLS_W'(1);
        else if (columns_reg > COLS_W'(MAX_COLUMNS))
            cols_eff = COLS_W'(MAX_COLUMNS);
        else
            cols_eff = columns_reg;

        if (rows_reg == '0)
            rows_eff = ROWS_W'(1);
        else if (rows_reg > ROWS_W'(MAX_ROWS))
            rows_eff = ROWS_W'(MAX_ROWS);
        else
            rows_eff = rows_reg;
    end

    assign col_last = ({1'b0, col_reg} == (cols_eff - COLS_W'(1)));
    assign row_last = ({1'b0, row_reg} == (rows_eff - ROWS_W'(1)));

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid & in_ready;

    // Pixel write address x + y*columns
    assign wr_sum    = 10'(pixel_y) * 10'(cols_eff) + 10'(pixel_x);
    assign buf_wr_en = in_fire && (action == ACTION_WRITE)
                       && (wr_sum < 10'(BUF_DEPTH));

    lmsgb_frame_buf u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (wr_sum[BUF_AW-1:0]),
        .wr_data (pixel_value),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Evaluate the pixel returned by the read port
    assign pix_on = pixel_on(rd_data, (mod3_reg == 2'd0), (mod7_reg == 3'd0),
                             blink_reg[0], blink_reg[1], blink_reg[2]);

    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Next state and counters
    always_comb
    begin
        state_next     = state_reg;
        frame_cnt_next = frame_cnt_reg;
        mod3_next      = mod3_reg;
        mod7_next      = mod7_reg;
        addr_next      = addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        rd_valid_next  = 1'b0;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;

        // drop the held beat once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // fold in the pixel read last cycle
        if (rd_valid_reg && pix_on)
            acc_next[rd_col_reg] = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (action == ACTION_FRAME) && enable_reg)
                begin
                    frame_cnt_next = frame_cnt_reg + 8'd1;
                    if (frame_cnt_next == 8'd0)
                    begin
                        mod3_next = 2'd0;
                        mod7_next = 3'd0;
                    end
                    else
                    begin
                        mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                        mod7_next = (mod7_reg == 3'd6) ? 3'd0 : mod7_reg + 3'd1;
                    end
                    addr_next  = '0;
                    col_next   = '0;
                    row_next   = '0;
                    acc_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one buffer read per cycle, address runs row-major
                rd_valid_next = 1'b1;
                addr_next     = addr_reg + buf_addr_t'(1);
                if (col_last)
                    state_next = ST_FLUSH;
                else
                    col_next = col_reg + COL_IW'(1);
            end
            ST_FLUSH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    col_next       = '0;
                    if (row_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        row_next   = row_reg + ROW_IW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_cnt_reg <= '0;
            mod3_reg      <= '0;
            mod7_reg      <= '0;
            addr_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_cnt_reg <= frame_cnt_next;
            mod3_reg      <= mod3_next;
            mod7_reg      <= mod7_next;
            addr_reg      <= addr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        rd_col_reg <= col_reg;
        if (in_fire)
            blink_reg <= {blink_slow, blink_mid, blink_fast};
        if (load_out)
        begin
            row_bits_reg    <= acc_reg;
            row_address_reg <= 4'(row_reg);
            last_row_reg    <= row_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_bits    = row_bits_reg;
    assign row_address = row_address_reg;
    assign last_row    = last_row_reg;

endmodule
`default_nettype wire

// ===== rtl/lmsgb_frame_buf.sv =====
`default_nettype none
module lmsgb_frame_buf (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire lmsgb_pkg::buf_addr_t wr_addr,
    input  wire lmsgb_pkg::pixel_t  wr_data,
    input  wire lmsgb_pkg::buf_addr_t rd_addr,
    output lmsgb_pkg::pixel_t       rd_data
);
    import lmsgb_pkg::*;

    pixel_t mem [BUF_DEPTH];
    pixel_t rd_data_reg;

    // Store one pixel byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lmsgb_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 20;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 15;
    localparam int FILL_ROWS    = 4;

    localparam pixel_t PX_FAST  = pixel_t'(1) << BIT_BLINK_FAST;
    localparam pixel_t PX_MID   = pixel_t'(1) << BIT_BLINK_MID;
    localparam pixel_t PX_SLOW  = pixel_t'(1) << BIT_BLINK_SLOW;
    localparam pixel_t PX_INV   = pixel_t'(1) << BIT_INVERT;
    localparam pixel_t PX_SPARE = 8'hC0;

    typedef struct packed {
        logic       action;
        logic [4:0] col;
        logic [3:0] row;
        pixel_t     value;
        logic       bf;
        logic       bm;
        logic       bs;
    } pix_item_t;

    typedef struct packed {
        logic [31:0] bits;
        logic [3:0]  addr;
        logic        last;
    } row_beat_t;

    typedef enum logic {
        STEP_CFG,
        STEP_ITEM
    } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        reg_idx_t    regsel;
        logic [31:0] cfg_val;
        pix_item_t   it;
        logic        typed;
        logic [31:0] typed_bits;
    } dir_step_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [4:0]  pixel_x;
    logic [3:0]  pixel_y;
    logic [7:0]  pixel_value;
    logic        blink_fast;
    logic        blink_mid;
    logic        blink_slow;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] row_bits;
    logic [3:0]  row_address;
    logic        last_row;

    // Shadow copy of the panel state
    pixel_t      pixel_mem [BUF_DEPTH];
    logic [7:0]  frame_count;
    logic [5:0]  cfg_columns;
    logic [4:0]  cfg_rows;
    logic        cfg_enable;
    row_beat_t   row_q [$];

    dir_step_t   dir_tab [$];
    int          fail_count;
    int          quiet_cycles;
    logic        calm;

    led_matrix_scan_with_grey_and_blink uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .blink_fast  (blink_fast),
        .blink_mid   (blink_mid),
        .blink_slow  (blink_slow),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_bits    (row_bits),
        .row_address (row_address),
        .last_row    (last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Class base state, then blink gate and invert on lit pixels only
    function automatic logic led_lit(pixel_t px, logic [7:0] cnt, logic bf, logic bm,
                                     logic bs);
        logic lit;
        case (px[1:0])
            CLASS_BRIGHT: lit = 1'b1;
            CLASS_SHADOW: lit = (cnt % 3) == 0;
            CLASS_DARK:   lit = (cnt % 7) == 0;
            default:      lit = 1'b0;
        endcase
        if (lit)
        begin
            if (px[BIT_BLINK_FAST])
                lit = bf;
            else if (px[BIT_BLINK_MID])
                lit = bm;
            else if (px[BIT_BLINK_SLOW])
                lit = bs;
            if (px[BIT_INVERT])
                lit = ~lit;
        end
        return lit;
    endfunction

    // Store a pixel or queue the rows one frame should produce
    task automatic predict_item(input pix_item_t it);
        int unsigned cols;
        int unsigned rows;
        int unsigned addr;
        int unsigned r;
        int unsigned c;
        row_beat_t   beat;
        cols = clamp_count(cfg_columns, MAX_COLUMNS);
        rows = clamp_count(cfg_rows, MAX_ROWS);
        if (it.action == ACTION_WRITE)
        begin
            addr = it.col + it.row * cols;
            if (addr < BUF_DEPTH)
                pixel_mem[addr] = it.value;
        end
        else if (cfg_enable)
        begin
            frame_count = frame_count + 8'd1;
            for (r = 0; r < rows; r++)
            begin
                beat.bits = '0;
                for (c = 0; c < cols; c++)
                begin
                    addr = r * cols + c;
                    if (addr < BUF_DEPTH && c < 32 &&
                        led_lit(pixel_mem[addr], frame_count, it.bf, it.bm, it.bs))
                        beat.bits[c] = 1'b1;
                end
                beat.addr = r[3:0];
                beat.last = (r + 1 == rows);
                row_q.push_back(beat);
            end
        end
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int unsigned idle_gap();
        int unsigned pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat on the input channel and hold it until taken
    task automatic push_item(input pix_item_t it, input logic typed,
                             input logic [31:0] typed_bits);
        int unsigned gap;
        row_beat_t   beat;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= it.action;
        pixel_x     <= it.col;
        pixel_y     <= it.row;
        pixel_value <= it.value;
        blink_fast  <= it.bf;
        blink_mid   <= it.bm;
        blink_slow  <= it.bs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(it);
        if (typed && it.action == ACTION_FRAME)
        begin
            beat = row_q.pop_back();
            beat.bits = typed_bits;
            row_q.push_back(beat);
        end
    endtask

    // Drop valid, wait for all rows, then let the block go quiet
    task automatic settle_panel();
        in_valid <= 1'b0;
        while (row_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Two-phase register write; the shadow copy follows the write edge
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COLUMNS: cfg_columns = val[5:0];
            REG_ROWS:    cfg_rows = val[4:0];
            REG_ENABLE:  cfg_enable = val[0];
            default:     ;
        endcase
    endtask

    function automatic pix_item_t mk_item(logic act, logic [4:0] col, logic [3:0] row,
                                          pixel_t value, logic bf, logic bm, logic bs);
        pix_item_t it;
        it.action = act;
        it.col    = col;
        it.row    = row;
        it.value  = value;
        it.bf     = bf;
        it.bm     = bm;
        it.bs     = bs;
        return it;
    endfunction

    function automatic pix_item_t rand_item(logic act);
        return mk_item(act, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic dir_step_t cfg_row(reg_idx_t idx, logic [31:0] val);
        dir_step_t s;
        s.kind       = STEP_CFG;
        s.regsel     = idx;
        s.cfg_val    = val;
        s.it         = '0;
        s.typed      = 1'b0;
        s.typed_bits = '0;
        return s;
    endfunction

    function automatic dir_step_t wr_row(logic [4:0] col, logic [3:0] row, pixel_t value);
        dir_step_t s;
        s.kind       = STEP_ITEM;
        s.regsel     = REG_NONE;
        s.cfg_val    = '0;
        s.it         = mk_item(ACTION_WRITE, col, row, value, 1'b0, 1'b0, 1'b0);
        s.typed      = 1'b0;
        s.typed_bits = '0;
        return s;
    endfunction

    function automatic dir_step_t frame_row(logic bf, logic bm, logic bs, logic typed,
                                            logic [31:0] typed_bits);
        dir_step_t s;
        s.kind       = STEP_ITEM;
        s.regsel     = REG_NONE;
        s.cfg_val    = '0;
        s.it         = mk_item(ACTION_FRAME, 5'd0, 4'd0, 8'd0, bf, bm, bs);
        s.typed      = typed;
        s.typed_bits = typed_bits;
        return s;
    endfunction

    // Receiver: hold out_ready low for random stretches
    initial
    begin
        int unsigned stall_left;
        int unsigned pick;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                stall_left = 0;
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick >= 95)
                    stall_left = $urandom_range(10, 40);
                else if (pick >= 70)
                    stall_left = $urandom_range(1, 3);
                out_ready <= 1'b1;
            end
        end
    end

    // Check each row beat against the oldest expected row; watch for a hang
    always @(posedge clk)
    begin : row_check
        row_beat_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (row_q.size() == 0)
                begin
                    $display("%0t: unexpected row beat, got bits %h addr %0d last %0b",
                             $time, row_bits, row_address, last_row);
                    fail_count++;
                end
                else
                begin
                    want = row_q.pop_front();
                    if (row_bits !== want.bits)
                    begin
                        $display("%0t: row_bits mismatch, expected %h, got %h",
                                 $time, want.bits, row_bits);
                        fail_count++;
                    end
                    if (row_address !== want.addr)
                    begin
                        $display("%0t: row_address mismatch, expected %0d, got %0d",
                                 $time, want.addr, row_address);
                        fail_count++;
                    end
                    if (last_row !== want.last)
                    begin
                        $display("%0t: last_row mismatch, expected %0b, got %0b",
                                 $time, want.last, last_row);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned ph;
        int unsigned n;
        int unsigned pick;
        logic [31:0] cols_val;
        logic [31:0] rows_val;
        logic [31:0] en_val;

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        action      <= ACTION_WRITE;
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_value <= '0;
        blink_fast  <= 1'b0;
        blink_mid   <= 1'b0;
        blink_slow  <= 1'b0;
        fail_count   = 0;
        quiet_cycles = 0;
        calm         = 1'b1;
        frame_count  = 8'd0;
        cfg_columns  = 6'd32;
        cfg_rows     = 5'd16;
        cfg_enable   = 1'b1;
        foreach (pixel_mem[i])
            pixel_mem[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the first buffer rows; every frame below scans only inside them
        for (int y = 0; y < FILL_ROWS; y++)
            for (int x = 0; x < MAX_COLUMNS; x++)
                push_item(mk_item(ACTION_WRITE, 5'(x), 4'(y), 8'($urandom_range(0, 255)),
                                  1'b0, 1'b0, 1'b0), 1'b0, '0);
        calm = 1'b0;

        // Directed: single-pixel panel first, then counts and the enable
        dir_tab.push_back(cfg_row(REG_COLUMNS, 32'd1));
        dir_tab.push_back(cfg_row(REG_ROWS, 32'd1));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_BRIGHT}));
        dir_tab.push_back(frame_row(1'b0, 1'b0, 1'b0, 1'b1, 32'd1));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_BRIGHT} | PX_FAST));
        dir_tab.push_back(frame_row(1'b0, 1'b1, 1'b1, 1'b1, 32'd0));
        dir_tab.push_back(frame_row(1'b1, 1'b0, 1'b0, 1'b1, 32'd1));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_BRIGHT} | PX_INV));
        dir_tab.push_back(frame_row(1'b1, 1'b1, 1'b1, 1'b1, 32'd0));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_OFF} | PX_INV));
        dir_tab.push_back(frame_row(1'b1, 1'b1, 1'b1, 1'b1, 32'd0));
        dir_tab.push_back(wr_row(5'd0, 4'd0,
                                 {6'd0, CLASS_BRIGHT} | PX_FAST | PX_MID | PX_SLOW));
        dir_tab.push_back(frame_row(1'b1, 1'b0, 1'b0, 1'b1, 32'd1));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_BRIGHT} | PX_MID | PX_SPARE));
        dir_tab.push_back(frame_row(1'b0, 1'b1, 1'b0, 1'b1, 32'd1));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_BRIGHT} | PX_SLOW));
        dir_tab.push_back(frame_row(1'b1, 1'b1, 1'b0, 1'b1, 32'd0));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_DARK}));
        dir_tab.push_back(frame_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
        dir_tab.push_back(wr_row(5'd0, 4'd0, {6'd0, CLASS_SHADOW}));
        dir_tab.push_back(frame_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_COLUMNS, 32'd0));
        dir_tab.push_back(cfg_row(REG_ROWS, 32'd0));
        dir_tab.push_back(frame_row(1'b1, 1'b0, 1'b1, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_ENABLE, 32'd0));
        dir_tab.push_back(frame_row(1'b1, 1'b1, 1'b1, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_ENABLE, 32'd1));
        dir_tab.push_back(cfg_row(REG_COLUMNS, 32'd63));
        dir_tab.push_back(cfg_row(REG_ROWS, 32'd4));
        dir_tab.push_back(wr_row(5'd31, 4'd3, 8'hFF));
        dir_tab.push_back(frame_row(1'b0, 1'b1, 1'b0, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_COLUMNS, 32'd5));
        dir_tab.push_back(cfg_row(REG_ROWS, 32'd31));
        dir_tab.push_back(wr_row(5'd31, 4'd3, {6'd0, CLASS_BRIGHT}));
        dir_tab.push_back(frame_row(1'b1, 1'b0, 1'b1, 1'b0, '0));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == STEP_CFG)
            begin
                settle_panel();
                cfg_write(dir_tab[i].regsel, dir_tab[i].cfg_val);
            end
            else
                push_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].typed_bits);
        end

        // Random phases: new geometry each phase, small panels most of the time
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            pick = $urandom_range(0, 9);
            cols_val = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd63 : (pick == 2) ? 32'd32 :
                       (pick == 3) ? $urandom_range(33, 63) : $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            rows_val = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd31 : (pick == 2) ? 32'd16 :
                       (pick == 3) ? $urandom_range(17, 31) : $urandom_range(1, 4);
            // Keep a full-width scan inside the loaded rows
            if (cols_val > 32'd8 && rows_val > 32'd4)
                rows_val = $urandom_range(1, 4);
            en_val = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'd1;
            settle_panel();
            calm = (ph == 1);
            cfg_write(REG_COLUMNS, cols_val);
            cfg_write(REG_ROWS, rows_val);
            cfg_write(REG_ENABLE, en_val);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold the sender once until every row has drained
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    settle_panel();
                push_item(rand_item(($urandom_range(0, 99) < 55) ? ACTION_FRAME :
                                    ACTION_WRITE), 1'b0, '0);
            end
        end

        calm = 1'b0;
        settle_panel();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
